### hw/rtl/stpq_pkg.sv
// Shared types and constants of the sorted task priority queue.
package stpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANK_WIDTH  = 10;
    localparam int TREE_WIDTH  = 8;
    localparam int NODE_WIDTH  = 16;
    localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [RANK_WIDTH-1:0] rank;
        logic [TREE_WIDTH-1:0] tree;
        logic [NODE_WIDTH-1:0] node;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

### hw/rtl/stpq_ifs.sv
// Valid/ready channel interfaces for task words and result words.
interface stpq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [stpq_pkg::RANK_WIDTH-1:0]   task_rank;
    logic [stpq_pkg::TREE_WIDTH-1:0]   tree_index;
    logic [stpq_pkg::NODE_WIDTH-1:0]   node_index;

    modport source (output valid, operation, task_rank, tree_index, node_index,
                    input ready);
    modport sink   (input valid, operation, task_rank, tree_index, node_index,
                    output ready);
endinterface

interface stpq_out_if;
    logic                              valid;
    logic                              ready;
    logic [stpq_pkg::RANK_WIDTH-1:0]   out_rank;
    logic [stpq_pkg::TREE_WIDTH-1:0]   out_tree;
    logic [stpq_pkg::NODE_WIDTH-1:0]   out_node;
    logic                              task_valid;
    logic                              is_empty;
    logic [stpq_pkg::COUNT_WIDTH-1:0]  entry_count;
    logic [1:0]                        status;

    modport source (output valid, out_rank, out_tree, out_node, task_valid, is_empty,
                    entry_count, status, input ready);
    modport sink   (input valid, out_rank, out_tree, out_node, task_valid, is_empty,
                    entry_count, status, output ready);
endinterface

### hw/rtl/stpq_cell.sv
// One slot of the sorted chain: compares the new key and shifts with its neighbours.
module stpq_cell (
    input  logic                i_clk,
    input  stpq_pkg::t_cell_ctl i_ctl,
    input  stpq_pkg::t_entry    i_new,
    input  logic                i_occ,
    input  logic                i_left_after,
    input  stpq_pkg::t_entry    i_left_entry,
    input  stpq_pkg::t_entry    i_right_entry,
    output logic                o_after,
    output stpq_pkg::t_entry    o_entry
);

    stpq_pkg::t_entry r_entry;

    // slot is empty or holds a key strictly after the new one
    assign o_after = !i_occ || ({r_entry.tree, r_entry.node} > {i_new.tree, i_new.node});
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_entry <= i_right_entry;
        end else if (i_ctl.insert && o_after) begin
            r_entry <= i_left_after ? i_left_entry : i_new;
        end
    end

endmodule

### hw/rtl/sorted_task_priority_queue.sv
// Sorted task queue of stpq_pkg::QUEUE_DEPTH slots built as a chain of compare-and-shift
// cells. Every slot compares the new key at once and shifts towards the tail on insert or
// towards the head on pop, so a new word is taken every cycle unless the output stalls;
// the result word appears in an output register in the cycle after acceptance, and a
// word is taken whenever that register is empty or being drained. Entries sort by tree
// then node, ties keep arrival order. Inserts into a full queue are dropped with status 1;
// pops on an empty queue give status 2 and zero task fields.
module sorted_task_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stpq_in_if.sink     i_task,
    stpq_out_if.source  o_result
);

    localparam int Depth = stpq_pkg::QUEUE_DEPTH;
    localparam int CntW  = stpq_pkg::COUNT_WIDTH;

    logic [CntW-1:0]     r_count;
    logic [CntW-1:0]     n_count;
    logic                r_out_valid;
    stpq_pkg::t_entry    r_out_entry;
    logic                r_out_task_valid;
    stpq_pkg::t_status   r_out_status;
    stpq_pkg::t_status   n_status;

    logic                accept;
    logic                is_pop;
    logic                full;
    logic                empty;
    stpq_pkg::t_cell_ctl ctl;
    stpq_pkg::t_entry    new_entry;
    logic                after   [Depth];
    stpq_pkg::t_entry    entries [Depth];

    assign i_task.ready = i_rst_n && (!r_out_valid || o_result.ready);
    assign accept       = i_task.valid && i_task.ready;
    assign is_pop       = (i_task.operation == stpq_pkg::OP_POP);
    assign full         = (r_count == CntW'(Depth));
    assign empty        = (r_count == '0);

    assign new_entry.rank = i_task.task_rank;
    assign new_entry.tree = i_task.tree_index;
    assign new_entry.node = i_task.node_index;

    assign ctl.insert = accept && !is_pop && !full;
    assign ctl.pop    = accept && is_pop && !empty;

    always_comb begin
        n_count  = r_count;
        n_status = stpq_pkg::ST_OK;
        if (ctl.insert) begin
            n_count = r_count + CntW'(1);
        end else if (ctl.pop) begin
            n_count = r_count - CntW'(1);
        end
        if (!is_pop && full) begin
            n_status = stpq_pkg::ST_FULL;
        end else if (is_pop && empty) begin
            n_status = stpq_pkg::ST_EMPTY;
        end
    end

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        logic             left_after;
        stpq_pkg::t_entry left_entry;
        stpq_pkg::t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_after = 1'b0;
            assign left_entry = new_entry;
        end else begin : g_body
            assign left_after = after[g-1];
            assign left_entry = entries[g-1];
        end

        if (g == Depth - 1) begin : g_tail
            assign right_entry = new_entry;
        end else begin : g_inner
            assign right_entry = entries[g+1];
        end

        stpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_new         (new_entry),
            .i_occ         (CntW'(g) < r_count),
            .i_left_after  (left_after),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_after       (after[g]),
            .o_entry       (entries[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_entry      <= ctl.pop ? entries[0] : '0;
            r_out_task_valid <= ctl.pop;
            r_out_status     <= n_status;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.out_rank    = r_out_entry.rank;
    assign o_result.out_tree    = r_out_entry.tree;
    assign o_result.out_node    = r_out_entry.node;
    assign o_result.task_valid  = r_out_task_valid;
    assign o_result.entry_count = r_count;
    assign o_result.is_empty    = (r_count == '0);
    assign o_result.status      = r_out_status;

endmodule

### hw/rtl/stpq_checker.sv
// Port-level checks on the sorted task queue, bound to the top level.
module stpq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [stpq_pkg::RANK_WIDTH-1:0]  i_out_rank,
    input logic                             i_task_valid,
    input logic                             i_is_empty,
    input logic [stpq_pkg::COUNT_WIDTH-1:0] i_entry_count,
    input logic [1:0]                       i_status
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rank)
            && $stable(i_entry_count) && $stable(i_status))
        else $error("result word changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_is_empty == (i_entry_count == '0))
        else $error("empty flag disagrees with count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == stpq_pkg::ST_FULL |->
            !i_task_valid && i_entry_count == stpq_pkg::COUNT_WIDTH'(stpq_pkg::QUEUE_DEPTH))
        else $error("dropped insert without a full queue");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == stpq_pkg::ST_EMPTY |->
            !i_task_valid && i_is_empty && i_out_rank == '0)
        else $error("pop on empty returned a task");

endmodule

bind sorted_task_priority_queue stpq_checker u_stpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_rank    (o_result.out_rank),
    .i_task_valid  (o_result.task_valid),
    .i_is_empty    (o_result.is_empty),
    .i_entry_count (o_result.entry_count),
    .i_status      (o_result.status)
);

### bench/tb_sorted_task_priority_queue.sv
// Self-checking testbench for the sorted task priority queue: directed and random task words.
`timescale 1ns / 100ps

typedef struct {
    logic [stpq_pkg::RANK_WIDTH-1:0]  rank;
    logic [stpq_pkg::TREE_WIDTH-1:0]  tree;
    logic [stpq_pkg::NODE_WIDTH-1:0]  node;
    logic                             task_valid;
    logic                             is_empty;
    logic [stpq_pkg::COUNT_WIDTH-1:0] count;
    stpq_pkg::t_status                status;
} t_result_word;

class t_queue_mirror;
    stpq_pkg::t_entry slots[stpq_pkg::QUEUE_DEPTH];
    int               occupancy;
    t_result_word     pending_results[$];
    int               failures;
    int               num_inserts, num_dropped, num_pops, num_empty_pops, num_full_hits;

    function new();
        occupancy      = 0;
        failures       = 0;
        num_inserts    = 0;
        num_dropped    = 0;
        num_pops       = 0;
        num_empty_pops = 0;
        num_full_hits  = 0;
    endfunction

    // Work out the reply to one accepted task word and queue it.
    function void take_task(stpq_pkg::t_op op, logic [stpq_pkg::RANK_WIDTH-1:0] rank,
                            logic [stpq_pkg::TREE_WIDTH-1:0] tree,
                            logic [stpq_pkg::NODE_WIDTH-1:0] node);
        t_result_word w;
        int           pos;
        w.rank       = '0;
        w.tree       = '0;
        w.node       = '0;
        w.task_valid = 1'b0;
        w.status     = stpq_pkg::ST_OK;
        if (op == stpq_pkg::OP_INSERT) begin
            num_inserts++;
            if (occupancy >= stpq_pkg::QUEUE_DEPTH) begin
                w.status = stpq_pkg::ST_FULL;
                num_dropped++;
            end else begin
                // new key goes behind every key that is not greater
                pos = occupancy;
                while (pos > 0 && {slots[pos-1].tree, slots[pos-1].node} > {tree, node}) begin
                    slots[pos] = slots[pos-1];
                    pos--;
                end
                slots[pos].rank = rank;
                slots[pos].tree = tree;
                slots[pos].node = node;
                occupancy++;
                if (occupancy == stpq_pkg::QUEUE_DEPTH)
                    num_full_hits++;
            end
        end else begin
            num_pops++;
            if (occupancy == 0) begin
                w.status = stpq_pkg::ST_EMPTY;
                num_empty_pops++;
            end else begin
                w.rank       = slots[0].rank;
                w.tree       = slots[0].tree;
                w.node       = slots[0].node;
                w.task_valid = 1'b1;
                for (int i = 1; i < occupancy; i++)
                    slots[i-1] = slots[i];
                occupancy--;
            end
        end
        w.is_empty = (occupancy == 0);
        w.count    = stpq_pkg::COUNT_WIDTH'(occupancy);
        pending_results = {pending_results, w};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void match_result(t_result_word got);
        t_result_word want;
        if (pending_results.size() == 0) begin
            $error("result word arrived with nothing expected");
            failures++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("out_rank", 32'(want.rank), 32'(got.rank));
        compare_field("out_tree", 32'(want.tree), 32'(got.tree));
        compare_field("out_node", 32'(want.node), 32'(got.node));
        compare_field("task_valid", 32'(want.task_valid), 32'(got.task_valid));
        compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        compare_field("entry_count", 32'(want.count), 32'(got.count));
        compare_field("status", 32'(want.status), 32'(got.status));
    endfunction

    function void close_out();
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            failures++;
        end
    endfunction
endclass

module tb_sorted_task_priority_queue;

    localparam int N_RANDOM   = 1300;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    stpq_in_if  task_if ();
    stpq_out_if result_if ();

    sorted_task_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (task_if),
        .o_result (result_if)
    );

    t_queue_mirror mirror = new();
    int            burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // drive one task word, holding valid across a burst
    task automatic send_word(stpq_pkg::t_op op, logic [stpq_pkg::RANK_WIDTH-1:0] rank,
                             logic [stpq_pkg::TREE_WIDTH-1:0] tree,
                             logic [stpq_pkg::NODE_WIDTH-1:0] node);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                task_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        task_if.valid      <= 1'b1;
        task_if.operation  <= op;
        task_if.task_rank  <= rank;
        task_if.tree_index <= tree;
        task_if.node_index <= node;
        @(posedge i_clk);
        while (!task_if.ready)
            @(posedge i_clk);
        burst_left--;
    endtask

    // receiver stall pattern: stretches of steady, random, sparse or periodic ready
    initial begin : sink_pacing
        int mode;
        int stretch;
        int cyc;
        mode    = 0;
        stretch = 0;
        cyc     = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(1, 40);
            end
            stretch--;
            cyc++;
            case (mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= 1'($urandom_range(0, 1));
                2: result_if.ready <= ($urandom_range(0, 3) == 0);
                default: result_if.ready <= (cyc % 3 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && task_if.valid && task_if.ready)
            mirror.take_task(stpq_pkg::t_op'(task_if.operation), task_if.task_rank,
                             task_if.tree_index, task_if.node_index);
    end

    always @(posedge i_clk) begin : result_monitor
        t_result_word got;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.rank       = result_if.out_rank;
            got.tree       = result_if.out_tree;
            got.node       = result_if.out_node;
            got.task_valid = result_if.task_valid;
            got.is_empty   = result_if.is_empty;
            got.count      = result_if.entry_count;
            got.status     = stpq_pkg::t_status'(result_if.status);
            mirror.match_result(got);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((task_if.valid && task_if.ready) || (result_if.valid && result_if.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int            items;
        int            phase_len;
        int            insert_pct;
        int            waited;
        bit            narrow;
        stpq_pkg::t_op op;
        logic [stpq_pkg::RANK_WIDTH-1:0] rank;
        logic [stpq_pkg::TREE_WIDTH-1:0] tree;
        logic [stpq_pkg::NODE_WIDTH-1:0] node;

        i_rst_n              <= 1'b0;
        task_if.valid        <= 1'b0;
        task_if.operation    <= stpq_pkg::OP_INSERT;
        task_if.task_rank    <= '0;
        task_if.tree_index   <= '0;
        task_if.node_index   <= '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, field extremes, key ties, fill to full and overflow
        send_word(stpq_pkg::OP_POP, '0, '0, '0);
        send_word(stpq_pkg::OP_INSERT, '1, '1, '1);
        send_word(stpq_pkg::OP_INSERT, '0, '0, '0);
        send_word(stpq_pkg::OP_INSERT, 10'd5, '0, '1);
        send_word(stpq_pkg::OP_INSERT, 10'd6, '1, '0);
        send_word(stpq_pkg::OP_INSERT, 10'd7, '0, '0);
        send_word(stpq_pkg::OP_INSERT, 10'd8, '0, '0);
        send_word(stpq_pkg::OP_POP, '0, '0, '0);
        for (int i = 0; i < 11; i++)
            send_word(stpq_pkg::OP_INSERT, stpq_pkg::RANK_WIDTH'(i * 93),
                      (i % 2) ? 8'hAA : 8'h55,
                      stpq_pkg::NODE_WIDTH'(16'h5A5A ^ (i * 16'h0F0F)));
        send_word(stpq_pkg::OP_INSERT, 10'd300, 8'd1, 16'd1);
        send_word(stpq_pkg::OP_POP, '0, '0, '0);
        send_word(stpq_pkg::OP_INSERT, 10'd301, 8'h55, 16'h5A5A);
        send_word(stpq_pkg::OP_INSERT, 10'd302, '0, '0);

        // random: phases biased towards filling, balancing or draining
        items = 0;
        while (items < N_RANDOM) begin
            phase_len = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0: insert_pct = 15;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            narrow = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < phase_len && items < N_RANDOM; k++) begin
                op   = ($urandom_range(0, 99) < insert_pct) ? stpq_pkg::OP_INSERT
                                                            : stpq_pkg::OP_POP;
                rank = stpq_pkg::RANK_WIDTH'($urandom);
                if (narrow) begin
                    tree = stpq_pkg::TREE_WIDTH'($urandom_range(0, 2));
                    node = stpq_pkg::NODE_WIDTH'($urandom_range(0, 3));
                end else begin
                    tree = stpq_pkg::TREE_WIDTH'($urandom);
                    node = stpq_pkg::NODE_WIDTH'($urandom);
                end
                send_word(op, rank, tree, node);
                items++;
            end
        end
        @(negedge i_clk);
        task_if.valid <= 1'b0;

        waited = 0;
        while (mirror.pending_results.size() != 0 && waited < IDLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        mirror.close_out();

        $display("Run covered %0d inserts (%0d dropped on a full queue, full %0d times)",
                 mirror.num_inserts, mirror.num_dropped, mirror.num_full_hits);
        $display("and %0d pops (%0d on an empty queue), with random sender and receiver stalls.",
                 mirror.num_pops, mirror.num_empty_pops);
        if (mirror.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
